// ===== hw/rtl/rrsp_pkg.sv =====
// Shared constants and types for the reply stream parser.
`timescale 1ns / 1ps
package rrsp_pkg;

    // Type bytes and delimiters
    localparam logic [7:0] CH_SIMPLE = 8'h2B;   // '+'
    localparam logic [7:0] CH_ERROR  = 8'h2D;   // '-'
    localparam logic [7:0] CH_INT    = 8'h3A;   // ':'
    localparam logic [7:0] CH_BULK   = 8'h24;   // '$'
    localparam logic [7:0] CH_ARRAY  = 8'h2A;   // '*'
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Element kind codes
    localparam logic [2:0] KIND_SIMPLE = 3'd0;
    localparam logic [2:0] KIND_ERROR  = 3'd1;
    localparam logic [2:0] KIND_INT    = 3'd2;
    localparam logic [2:0] KIND_BULK   = 3'd3;
    localparam logic [2:0] KIND_ARRAY  = 3'd4;

    // Request from the parser to the count stack
    typedef struct packed {
        logic push;     // open a new array level
        logic finish;   // an element completed: count it off
    } t_stk_req;

endpackage

// ===== hw/rtl/rrsp_stack.sv =====
// Stack of remaining element counts for open arrays, unwound by one combinational search.
`timescale 1ns / 1ps
module rrsp_stack #(
    parameter int MAX_DEPTH   = 8,
    parameter int COUNT_WIDTH = 32,
    parameter int LW          = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rrsp_pkg::t_stk_req     i_req,
    input  logic [COUNT_WIDTH-2:0] i_push_value,
    output logic [LW-1:0]          o_level,
    output logic [LW-1:0]          o_fin_level,
    output logic                   o_full,
    output logic                   o_done
);
    import rrsp_pkg::*;

    logic [COUNT_WIDTH-2:0] r_cnt [MAX_DEPTH];
    logic [MAX_DEPTH-1:0]   r_one;      // entry holds a count of one
    logic [LW-1:0]          r_level;

    logic [MAX_DEPTH-1:0]   live;
    logic                   hit;
    logic [LW-1:0]          hit_idx;

    // Topmost open level that does not close when decremented
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int k = 0; k < MAX_DEPTH; k++) begin
            live[k] = (LW'(k) < r_level) && !r_one[k];
            if (live[k]) begin
                hit     = 1'b1;
                hit_idx = LW'(k);
            end
        end
    end

    // Level pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
        end else if (i_req.push) begin
            r_level <= r_level + 1'b1;
        end else if (i_req.finish) begin
            r_level <= o_fin_level;
        end
    end

    // Per-level count registers, each with its own decrementer
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_DEPTH; k++) begin
            if (i_req.push && r_level == LW'(k)) begin
                r_cnt[k] <= i_push_value;
                r_one[k] <= (i_push_value == (COUNT_WIDTH-1)'(1));
            end else if (i_req.finish && hit && hit_idx == LW'(k)) begin
                r_cnt[k] <= r_cnt[k] - 1'b1;
                r_one[k] <= (r_cnt[k] == (COUNT_WIDTH-1)'(2));
            end
        end
    end

    assign o_level     = r_level;
    assign o_fin_level = hit ? hit_idx + 1'b1 : '0;
    assign o_full      = (r_level == LW'(MAX_DEPTH));
    assign o_done      = !hit;

endmodule

// ===== hw/rtl/resp_reply_stream_parser.sv =====
// Top level of the reply stream parser: byte decoder, result register and count stack.
//
// Usage:
//   Slave side (i_s_*) takes one byte of the reply stream per request.
//   Master side (o_m_*) returns exactly one result per byte, in order.
//   o_m_tdata  : [7:0] data_byte, [11:8] nest_depth, [43:12] header_value,
//                [44] protocol_error, [47:45] zero.
//   o_m_tuser  : [0] is_payload, [3:1] element_kind, [4] element_start,
//                [5] element_end, [6] is_nil.
//   o_m_tlast  : reply_done, a whole top-level reply completed on this byte.
// The result is valid in the cycle after the byte is accepted. Throughput is one byte
// per cycle unless the receiver stalls; the decode, the length shift-add and the stack
// unwinding search over the per-level "count is one" flags all sit in one cycle.
// The result register holds one result; while the receiver stalls, o_s_tready
// stays high only if that result is taken in the same cycle.
// Synchronous reset (i_rst_n low) returns to awaiting a type byte, empties the
// stack and clears the sticky protocol error; stack counts need no clearing.
`timescale 1ns / 1ps
module resp_reply_stream_parser #(
    parameter int MAX_DEPTH   = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,    // [7:0] in_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [47:0] o_m_tdata,    // data_byte, nest_depth, header_value, protocol_error
    output logic [6:0]  o_m_tuser,    // is_payload, element_kind, start, end, is_nil
    output logic        o_m_tlast     // reply_done
);
    import rrsp_pkg::*;

    localparam int CW = COUNT_WIDTH;
    localparam int LW = $clog2(MAX_DEPTH + 1);
    localparam logic [CW+2:0] MagLimit = {4'b0, {(CW-1){1'b1}}};

    typedef enum logic [3:0] {
        PH_TYPE, PH_LINE, PH_LINE_LF, PH_HDR, PH_HDR_LF,
        PH_BULK, PH_TRAIL1, PH_TRAIL2, PH_ERR
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [2:0]      r_kind, n_kind;
    logic [CW-2:0]   r_accum, n_accum;
    logic            r_minus, n_minus;
    logic            r_digit, n_digit;
    logic [CW-2:0]   r_bulk, n_bulk;
    logic            r_err, n_err;

    logic            r_m_valid;
    logic [47:0]     r_m_data;
    logic [6:0]      r_m_user;
    logic            r_m_last;

    logic            s_acc;
    logic [7:0]      b;
    t_stk_req        stk_req;
    logic [LW-1:0]   stk_level;
    logic [LW-1:0]   stk_fin_level;
    logic            stk_full;
    logic            stk_done;

    logic [CW+2:0]   acc_x, acc_v;
    logic [CW-1:0]   acc_w, hval;
    logic            neg, nil_len;
    logic [LW+3:0]   lvl_ext;

    logic            f_payload, f_start, f_end, f_nil, f_done;
    logic [2:0]      f_kind;
    logic [31:0]     f_hval;
    logic            push_c, finish_c;

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_m_valid || i_m_tready;
    assign b          = i_s_tdata;

    // Header arithmetic
    assign acc_x   = (CW+3)'(r_accum);
    assign acc_v   = (acc_x << 3) + (acc_x << 1) + (CW+3)'(b - CH_ZERO);
    assign acc_w   = {1'b0, r_accum};
    assign neg     = r_minus && (r_accum != '0);
    assign nil_len = r_minus && (r_accum == (CW-1)'(1));
    assign hval    = neg ? (~acc_w + 1'b1) : acc_w;

    // Per-byte decode
    always_comb begin
        n_phase   = r_phase;
        n_kind    = r_kind;
        n_accum   = r_accum;
        n_minus   = r_minus;
        n_digit   = r_digit;
        n_bulk    = r_bulk;
        n_err     = r_err;
        f_payload = 1'b0;
        f_kind    = KIND_SIMPLE;
        f_start   = 1'b0;
        f_end     = 1'b0;
        f_nil     = 1'b0;
        f_done    = 1'b0;
        f_hval    = '0;
        push_c    = 1'b0;
        finish_c  = 1'b0;
        case (r_phase)
            PH_TYPE: begin
                n_accum = '0;
                n_minus = 1'b0;
                n_digit = 1'b0;
                f_start = 1'b1;
                case (b)
                    CH_SIMPLE: begin f_kind = KIND_SIMPLE; n_phase = PH_LINE; end
                    CH_ERROR:  begin f_kind = KIND_ERROR;  n_phase = PH_LINE; end
                    CH_INT:    begin f_kind = KIND_INT;    n_phase = PH_LINE; end
                    CH_BULK:   begin f_kind = KIND_BULK;   n_phase = PH_HDR;  end
                    CH_ARRAY:  begin f_kind = KIND_ARRAY;  n_phase = PH_HDR;  end
                    default:   begin n_err = 1'b1; n_phase = PH_ERR; end
                endcase
                n_kind = f_kind;
            end
            PH_LINE: begin
                f_kind = r_kind;
                if (b == CH_CR) begin
                    n_phase = PH_LINE_LF;
                end else begin
                    f_payload = 1'b1;
                end
            end
            PH_LINE_LF: begin
                f_kind   = r_kind;
                f_end    = 1'b1;
                finish_c = 1'b1;
                f_done   = stk_done;
                n_phase  = PH_TYPE;
            end
            PH_HDR: begin
                f_kind = r_kind;
                if (b == CH_CR) begin
                    if (!r_digit) begin
                        n_err = 1'b1;
                    end else if (r_kind == KIND_BULK && r_minus
                                 && r_accum > (CW-1)'(1)) begin
                        n_err = 1'b1;
                    end else begin
                        n_phase = PH_HDR_LF;
                    end
                end else if (b == CH_MINUS) begin
                    if (r_minus || r_digit) begin
                        n_err = 1'b1;
                    end else begin
                        n_minus = 1'b1;
                    end
                end else if (b inside {[CH_ZERO:CH_NINE]}) begin
                    if (acc_v > MagLimit) begin
                        n_err = 1'b1;
                    end else begin
                        n_accum = acc_v[CW-2:0];
                        n_digit = 1'b1;
                    end
                end else begin
                    n_err = 1'b1;
                end
                if (n_err) begin
                    n_phase = PH_ERR;
                end
            end
            PH_HDR_LF: begin
                f_kind = r_kind;
                f_hval = 32'(hval);
                f_nil  = nil_len;
                if (r_kind == KIND_BULK) begin
                    if (nil_len) begin
                        f_end    = 1'b1;
                        finish_c = 1'b1;
                        f_done   = stk_done;
                        n_phase  = PH_TYPE;
                    end else begin
                        n_bulk  = r_accum;
                        n_phase = (r_accum != '0) ? PH_BULK : PH_TRAIL1;
                    end
                end else if (nil_len || neg || r_accum == '0) begin
                    f_end    = 1'b1;
                    finish_c = 1'b1;
                    f_done   = stk_done;
                    n_phase  = PH_TYPE;
                end else if (stk_full) begin
                    n_err   = 1'b1;
                    n_phase = PH_ERR;
                end else begin
                    push_c  = 1'b1;
                    n_phase = PH_TYPE;
                end
            end
            PH_BULK: begin
                f_kind    = r_kind;
                f_payload = 1'b1;
                n_bulk    = r_bulk - 1'b1;
                if (r_bulk == (CW-1)'(1)) begin
                    n_phase = PH_TRAIL1;
                end
            end
            PH_TRAIL1: begin
                f_kind  = r_kind;
                n_phase = PH_TRAIL2;
            end
            PH_TRAIL2: begin
                f_kind   = r_kind;
                f_end    = 1'b1;
                finish_c = 1'b1;
                f_done   = stk_done;
                n_phase  = PH_TYPE;
            end
            default: begin
                n_err   = 1'b1;
                n_phase = PH_ERR;
            end
        endcase
        // Latched error blanks everything but the echo, the depth and the error flag
        if (n_err) begin
            n_kind    = r_kind;
            f_payload = 1'b0;
            f_kind    = KIND_SIMPLE;
            f_start   = 1'b0;
            f_end     = 1'b0;
            f_nil     = 1'b0;
            f_done    = 1'b0;
            f_hval    = '0;
            push_c    = 1'b0;
            finish_c  = 1'b0;
        end
    end

    assign stk_req.push   = s_acc && push_c;
    assign stk_req.finish = s_acc && finish_c;

    rrsp_stack #(
        .MAX_DEPTH  (MAX_DEPTH),
        .COUNT_WIDTH(COUNT_WIDTH),
        .LW         (LW)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (stk_req),
        .i_push_value(r_accum),
        .o_level     (stk_level),
        .o_fin_level (stk_fin_level),
        .o_full      (stk_full),
        .o_done      (stk_done)
    );

    // Depth after this byte: push adds one, finish unwinds to the surviving level
    always_comb begin
        lvl_ext = {4'b0, stk_level};
        if (push_c) begin
            lvl_ext = lvl_ext + 1'b1;
        end else if (finish_c) begin
            lvl_ext = {4'b0, stk_fin_level};
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_kind  <= KIND_SIMPLE;
            r_accum <= '0;
            r_minus <= 1'b0;
            r_digit <= 1'b0;
            r_bulk  <= '0;
            r_err   <= 1'b0;
        end else if (s_acc) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_accum <= n_accum;
            r_minus <= n_minus;
            r_digit <= n_digit;
            r_bulk  <= n_bulk;
            r_err   <= n_err;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (s_acc) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_m_data <= {3'b0, n_err, f_hval, lvl_ext[3:0], b};
            r_m_user <= {f_nil, f_end, f_start, f_kind, f_payload};
            r_m_last <= f_done;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;
    assign o_m_tlast  = r_m_last;

endmodule

// ===== bench/tb_resp_reply_stream_parser.sv =====
// Self-checking bench for the reply stream parser: byte stimulus, result prediction and compare.
`timescale 1ns / 1ps
module tb_resp_reply_stream_parser;
    import rrsp_pkg::*;

    localparam int DEPTH_LIMIT = 8;
    localparam int COUNT_BITS  = 32;
    localparam longint unsigned MAG_LIMIT = (64'd1 << (COUNT_BITS - 1)) - 64'd1;
    localparam int RANDOM_BYTES = 1850;
    localparam int CALM_TAIL    = 200;

    // Parser phases of the predictor
    typedef enum logic [3:0] {
        AWAIT_TYPE, LINE_BODY, LINE_TAIL, HDR_DIGITS, HDR_TAIL,
        BULK_DATA, BULK_TRAIL1, BULK_TRAIL2, STUCK
    } t_parse_phase;

    // One result, field by field
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_payload;
        logic [2:0]  kind;
        logic        elem_start;
        logic        elem_end;
        logic        is_nil;
        logic [3:0]  depth;
        logic [31:0] hdr_val;
        logic        reply_done;
        logic        proto_err;
    } t_reply_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = '0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [47:0] o_m_tdata;
    logic [6:0]  o_m_tuser;
    logic        o_m_tlast;

    // Stimulus and scoreboard storage
    logic [7:0]    byte_feed[$];
    t_reply_result expected_results[$];
    int            total_bytes = 0;
    int            accepted_count = 0;
    int            results_seen = 0;
    int            mismatch_count = 0;
    int            s_gap = 0;
    int            m_gap = 0;
    logic          calm = 1'b0;
    logic          hold_long = 1'b0;
    t_reply_result want_res;
    t_reply_result got_res;

    // Predictor state
    t_parse_phase    phase;
    logic [2:0]      cur_kind;
    longint unsigned len_acc;
    logic            minus_seen;
    logic            digit_seen;
    longint unsigned bulk_left;
    longint unsigned level_counts[DEPTH_LIMIT];
    int              open_levels;
    logic            err_latched;

    resp_reply_stream_parser #(
        .MAX_DEPTH  (DEPTH_LIMIT),
        .COUNT_WIDTH(COUNT_BITS)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser),
        .o_m_tlast (o_m_tlast)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void reset_parser();
        phase       = AWAIT_TYPE;
        cur_kind    = KIND_SIMPLE;
        len_acc     = 0;
        minus_seen  = 1'b0;
        digit_seen  = 1'b0;
        bulk_left   = 0;
        open_levels = 0;
        err_latched = 1'b0;
        foreach (level_counts[i]) level_counts[i] = 0;
    endfunction

    function automatic void latch_error();
        err_latched = 1'b1;
        phase       = STUCK;
    endfunction

    // Element done: count it off the open arrays; 1 when the top level closes
    function automatic logic count_off_element();
        while (open_levels > 0) begin
            level_counts[open_levels-1] = level_counts[open_levels-1] - 1;
            if (level_counts[open_levels-1] != 0) return 1'b0;
            open_levels = open_levels - 1;
        end
        return 1'b1;
    endfunction

    function automatic t_reply_result parse_byte(input logic [7:0] b);
        t_reply_result   r;
        longint unsigned grown;
        logic            neg;
        r = '0;
        case (phase)
            AWAIT_TYPE: begin
                case (b)
                    CH_SIMPLE: begin r.kind = KIND_SIMPLE; phase = LINE_BODY;  end
                    CH_ERROR:  begin r.kind = KIND_ERROR;  phase = LINE_BODY;  end
                    CH_INT:    begin r.kind = KIND_INT;    phase = LINE_BODY;  end
                    CH_BULK:   begin r.kind = KIND_BULK;   phase = HDR_DIGITS; end
                    CH_ARRAY:  begin r.kind = KIND_ARRAY;  phase = HDR_DIGITS; end
                    default:   latch_error();
                endcase
                if (!err_latched) begin
                    r.elem_start = 1'b1;
                    cur_kind     = r.kind;
                    len_acc      = 0;
                    minus_seen   = 1'b0;
                    digit_seen   = 1'b0;
                end
            end
            LINE_BODY: begin
                r.kind = cur_kind;
                if (b == CH_CR) phase = LINE_TAIL;
                else r.is_payload = 1'b1;
            end
            LINE_TAIL: begin
                r.kind       = cur_kind;
                r.elem_end   = 1'b1;
                r.reply_done = count_off_element();
                phase        = AWAIT_TYPE;
            end
            HDR_DIGITS: begin
                r.kind = cur_kind;
                if (b == CH_CR) begin
                    if (!digit_seen) latch_error();
                    else if (cur_kind == KIND_BULK && minus_seen && len_acc > 1) latch_error();
                    else phase = HDR_TAIL;
                end else if (b == CH_MINUS) begin
                    if (minus_seen || digit_seen) latch_error();
                    else minus_seen = 1'b1;
                end else if (b >= CH_ZERO && b <= CH_NINE) begin
                    grown = len_acc * 10 + longint'(b - CH_ZERO);
                    if (grown > MAG_LIMIT) latch_error();
                    else begin
                        len_acc    = grown;
                        digit_seen = 1'b1;
                    end
                end else begin
                    latch_error();
                end
            end
            HDR_TAIL: begin
                neg       = minus_seen && len_acc != 0;
                r.kind    = cur_kind;
                r.hdr_val = neg ? (32'd0 - len_acc[31:0]) : len_acc[31:0];
                r.is_nil  = minus_seen && len_acc == 1;
                if (cur_kind == KIND_BULK) begin
                    if (r.is_nil) begin
                        r.elem_end   = 1'b1;
                        r.reply_done = count_off_element();
                        phase        = AWAIT_TYPE;
                    end else begin
                        bulk_left = len_acc;
                        phase     = (len_acc != 0) ? BULK_DATA : BULK_TRAIL1;
                    end
                end else if (r.is_nil || neg || len_acc == 0) begin
                    // nil, empty or negative count: closes at once
                    r.elem_end   = 1'b1;
                    r.reply_done = count_off_element();
                    phase        = AWAIT_TYPE;
                end else if (open_levels >= DEPTH_LIMIT) begin
                    latch_error();
                end else begin
                    level_counts[open_levels] = len_acc;
                    open_levels = open_levels + 1;
                    phase       = AWAIT_TYPE;
                end
            end
            BULK_DATA: begin
                r.kind       = cur_kind;
                r.is_payload = 1'b1;
                if (bulk_left > 0) bulk_left = bulk_left - 1;
                if (bulk_left == 0) phase = BULK_TRAIL1;
            end
            BULK_TRAIL1: begin
                r.kind = cur_kind;
                phase  = BULK_TRAIL2;
            end
            BULK_TRAIL2: begin
                r.kind       = cur_kind;
                r.elem_end   = 1'b1;
                r.reply_done = count_off_element();
                phase        = AWAIT_TYPE;
            end
            default: latch_error();
        endcase
        // once broken, only the byte echo, the depth and the error flag remain
        if (err_latched) r = '0;
        r.data_byte = b;
        r.depth     = open_levels[3:0];
        r.proto_err = err_latched;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        b = CH_CR;
        while (b == CH_CR) b = 8'($urandom_range(0, 255));
        return b;
    endfunction

    task automatic put(input logic [7:0] b);
        byte_feed.insert(byte_feed.size(), b);
    endtask

    task automatic put_line(input logic [7:0] type_ch, input int n);
        put(type_ch);
        repeat (n) put(rand_text_byte());
        put(CH_CR);
        put(8'($urandom_range(0, 255)));
    endtask

    // type byte, optional minus, leading zeros, decimal magnitude, CR, loose byte
    task automatic put_header(input logic [7:0] type_ch, input logic neg,
                              input longint unsigned mag, input int zeros);
        string digits;
        digits = $sformatf("%0d", mag);
        put(type_ch);
        if (neg) put(CH_MINUS);
        repeat (zeros) put(CH_ZERO);
        for (int i = 0; i < digits.len(); i++) put(digits[i]);
        put(CH_CR);
        put(8'($urandom_range(0, 255)));
    endtask

    task automatic put_bulk(input logic neg, input longint unsigned mag, input int zeros);
        put_header(CH_BULK, neg, mag, zeros);
        if (!(neg && mag == 1)) begin
            repeat (mag) put(8'($urandom_range(0, 255)));
            put(8'($urandom_range(0, 255)));
            put(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic gen_element(input int depth);
        int pick;
        int sel;
        int cnt;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 19);
        if (pick < 12) begin
            put_line(CH_SIMPLE, $urandom_range(0, 8));
        end else if (pick < 20) begin
            put_line(CH_ERROR, $urandom_range(0, 8));
        end else if (pick < 30) begin
            put_line(CH_INT, $urandom_range(0, 6));
        end else if (pick < 65 || depth >= DEPTH_LIMIT || $urandom_range(0, depth) != 0) begin
            case (sel)
                0:       put_bulk(1'b1, 1, 0);
                1:       put_bulk(1'b1, 0, $urandom_range(0, 2));
                2:       put_bulk(1'b0, $urandom_range(11, 60), 0);
                default: put_bulk(1'b0, $urandom_range(0, 10), ($urandom_range(0, 7) == 0));
            endcase
        end else begin
            case (sel)
                0: put_header(CH_ARRAY, 1'b1, 1, 0);
                1: put_header(CH_ARRAY, 1'b1, 0, $urandom_range(0, 2));
                2: put_header(CH_ARRAY, 1'b1, $urandom_range(2, 32'h7FFF_FFFF), 0);
                3: put_header(CH_ARRAY, 1'b0, 0, $urandom_range(0, 2));
                default: begin
                    cnt = $urandom_range(1, 3);
                    put_header(CH_ARRAY, 1'b0, cnt, ($urandom_range(0, 3) == 0));
                    repeat (cnt) gen_element(depth + 1);
                end
            endcase
        end
    endtask

    // One malformed reply at the very end; the error then sticks for good
    task automatic put_broken_reply();
        logic [7:0] b;
        int sel;
        string big;
        sel = $urandom_range(0, 6);
        big = "2147483648";
        if ($urandom_range(0, 1) == 1) put_header(CH_ARRAY, 1'b0, 3, 0);
        case (sel)
            0: begin
                // unknown type byte
                b = CH_SIMPLE;
                while (b == CH_SIMPLE || b == CH_ERROR || b == CH_INT ||
                       b == CH_BULK || b == CH_ARRAY)
                    b = 8'($urandom_range(0, 255));
                put(b);
            end
            1: begin
                // stray character inside a length
                b = CH_ZERO;
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_CR || b == CH_MINUS)
                    b = 8'($urandom_range(0, 255));
                put(CH_BULK);
                put(8'h31);
                put(b);
            end
            2: begin
                // CR before any digit
                put(($urandom_range(0, 1) == 1) ? CH_ARRAY : CH_BULK);
                if ($urandom_range(0, 1) == 1) put(CH_MINUS);
                put(CH_CR);
            end
            3: begin
                // magnitude one past the limit
                put(($urandom_range(0, 1) == 1) ? CH_ARRAY : CH_BULK);
                if ($urandom_range(0, 1) == 1) put(CH_MINUS);
                for (int i = 0; i < big.len(); i++) put(big[i]);
            end
            4: begin
                // minus after a digit, or a second minus
                put(CH_ARRAY);
                put(($urandom_range(0, 1) == 1) ? CH_MINUS : 8'h35);
                put(CH_MINUS);
            end
            5: put_header(CH_BULK, 1'b1, $urandom_range(2, 1000), 0);
            default: begin
                // one level more than the stack holds
                repeat (DEPTH_LIMIT + 1) put_header(CH_ARRAY, 1'b0, 1, 0);
                put_line(CH_INT, 1);
            end
        endcase
        repeat (20) put(8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // Driver: one byte request per handshake
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
            s_gap    <= 0;
            reset_parser();
        end else begin
            if (s_tvalid && o_s_tready) begin
                expected_results.insert(expected_results.size(), parse_byte(s_tdata));
                accepted_count <= accepted_count + 1;
            end
            if (!s_tvalid || o_s_tready) begin
                if (s_gap > 0) begin
                    s_gap    <= s_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (byte_feed.size() == 0) begin
                    s_tvalid <= 1'b0;
                end else if (!calm && !hold_long && $urandom_range(0, 7) == 0) begin
                    s_gap    <= $urandom_range(0, 11);
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= byte_feed.pop_front();
                end
            end
            calm <= (byte_feed.size() < CALM_TAIL);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction
    // ---------------------------------------------------------------
    task automatic compare_field(input string name, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got) begin
            if (mismatch_count < 10)
                $display("Mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                         results_seen, name, want, got);
            mismatch_count = mismatch_count + 1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
            m_gap    <= 0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                got_res.data_byte  = o_m_tdata[7:0];
                got_res.depth      = o_m_tdata[11:8];
                got_res.hdr_val    = o_m_tdata[43:12];
                got_res.proto_err  = o_m_tdata[44];
                got_res.is_payload = o_m_tuser[0];
                got_res.kind       = o_m_tuser[3:1];
                got_res.elem_start = o_m_tuser[4];
                got_res.elem_end   = o_m_tuser[5];
                got_res.is_nil     = o_m_tuser[6];
                got_res.reply_done = o_m_tlast;
                if (expected_results.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("Unexpected result %0d: tdata 0x%0h tuser 0x%0h",
                                 results_seen, o_m_tdata, o_m_tuser);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want_res = expected_results.pop_front();
                    compare_field("data_byte",      want_res.data_byte,  got_res.data_byte);
                    compare_field("is_payload",     want_res.is_payload, got_res.is_payload);
                    compare_field("element_kind",   want_res.kind,       got_res.kind);
                    compare_field("element_start",  want_res.elem_start, got_res.elem_start);
                    compare_field("element_end",    want_res.elem_end,   got_res.elem_end);
                    compare_field("is_nil",         want_res.is_nil,     got_res.is_nil);
                    compare_field("nest_depth",     want_res.depth,      got_res.depth);
                    compare_field("header_value",   want_res.hdr_val,    got_res.hdr_val);
                    compare_field("reply_done",     want_res.reply_done, got_res.reply_done);
                    compare_field("protocol_error", want_res.proto_err,  got_res.proto_err);
                    compare_field("tdata pad",      0,                   o_m_tdata[47:45]);
                end
                results_seen = results_seen + 1;
            end
            // receiver stalls: long hold-off, random bursts, none in the tail
            if (hold_long) begin
                m_tready <= 1'b0;
            end else if (m_gap > 0) begin
                m_gap    <= m_gap - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_gap    <= $urandom_range(0, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Long receiver hold-off so the result register fills and input stalls
    initial begin
        while (accepted_count < 400) @(posedge i_clk);
        hold_long <= 1'b1;
        repeat (80) @(posedge i_clk);
        hold_long <= 1'b0;
    end

    initial begin
        #2_500_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        // directed: byte extremes, every kind, nil, negative zero, empty arrays
        put(CH_SIMPLE); put(8'h00); put(8'hFF); put(CH_CR); put(8'hFF);
        put_line(CH_ERROR, 3);
        put_line(CH_INT, 0);
        put_bulk(1'b0, 0, 0);
        put_bulk(1'b1, 1, 0);
        put_bulk(1'b1, 0, 0);
        put_header(CH_BULK, 1'b0, 2, 2); put(CH_CR); put(8'h00); put(8'h0D); put(8'h0A);
        put_header(CH_ARRAY, 1'b0, 0, 0);
        put_header(CH_ARRAY, 1'b1, 1, 0);
        put_header(CH_ARRAY, 1'b1, MAG_LIMIT, 0);
        put_header(CH_ARRAY, 1'b1, 0, 1);
        repeat (DEPTH_LIMIT) put_header(CH_ARRAY, 1'b0, 1, 0);
        put_line(CH_INT, 1);
        put_header(CH_ARRAY, 1'b0, 2, 0);
        put_bulk(1'b0, 1, 0);
        put_line(CH_SIMPLE, 1);

        // random well-formed replies, now and then a deep chain
        while (byte_feed.size() < RANDOM_BYTES) begin
            if ($urandom_range(0, 24) == 0) begin
                repeat ($urandom_range(5, DEPTH_LIMIT)) put_header(CH_ARRAY, 1'b0, 1, 0);
                gen_element(DEPTH_LIMIT);
            end else begin
                gen_element(0);
            end
        end
        put_broken_reply();
        total_bytes = byte_feed.size();

        while (accepted_count < total_bytes) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== resp_reply_stream_parser.f =====
hw/rtl/rrsp_pkg.sv
hw/rtl/rrsp_stack.sv
hw/rtl/resp_reply_stream_parser.sv
bench/tb_resp_reply_stream_parser.sv
